// ===== hw/rtl/bmpd_pkg.sv =====
`default_nettype none
package bmpd_pkg;

  // size limits handed to the top level as parameter defaults
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // output field widths fixed by the interface
  localparam int COORD_W = 12;
  localparam int SIZE_W  = 13;

  typedef logic [7:0]         byte_t;
  typedef logic [1:0]         kind_t;
  typedef logic [3:0]         err_t;
  typedef logic [5:0]         hdr_idx_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]  size_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXELS
  } phase_t;

  // result kinds
  localparam kind_t KIND_PIXEL  = 2'd0;
  localparam kind_t KIND_HEADER = 2'd1;
  localparam kind_t KIND_ERROR  = 2'd2;

  // error codes, lower value has priority
  localparam err_t ERR_SIGNATURE   = 4'd0;
  localparam err_t ERR_OFFSET      = 4'd1;
  localparam err_t ERR_INFO_SIZE   = 4'd2;
  localparam err_t ERR_PLANES      = 4'd3;
  localparam err_t ERR_DEPTH       = 4'd4;
  localparam err_t ERR_COMPRESSION = 4'd5;
  localparam err_t ERR_PALETTE     = 4'd6;
  localparam err_t ERR_SIZE        = 4'd7;
  localparam err_t ERR_TRUNCATED   = 4'd8;
  localparam err_t NO_FAIL         = 4'd15;

  // expected header field values
  localparam logic [15:0] SIG_BM       = 16'h4D42;
  localparam logic [31:0] PIXEL_OFFSET = 32'd54;
  localparam logic [31:0] INFO_SIZE    = 32'd40;
  localparam logic [15:0] PLANES       = 16'd1;
  localparam logic [15:0] BITS_PER_PIX = 16'd24;

  // header byte positions at which a field completes
  localparam hdr_idx_t IDX_SIG      = 6'd1;
  localparam hdr_idx_t IDX_OFFSET   = 6'd13;
  localparam hdr_idx_t IDX_INFO     = 6'd17;
  localparam hdr_idx_t IDX_WIDTH    = 6'd21;
  localparam hdr_idx_t IDX_HEIGHT   = 6'd25;
  localparam hdr_idx_t IDX_PLANES   = 6'd27;
  localparam hdr_idx_t IDX_DEPTH    = 6'd29;
  localparam hdr_idx_t IDX_COMPRESS = 6'd33;
  localparam hdr_idx_t IDX_PALETTE  = 6'd49;
  localparam hdr_idx_t IDX_LAST     = 6'd53;

  typedef struct packed {
    byte_t data_byte;
    logic  file_start;
  } item_t;

  typedef struct packed {
    kind_t  result_kind;
    err_t   error_code;
    byte_t  red;
    byte_t  green;
    byte_t  blue;
    coord_t column;
    coord_t row;
    logic   last_pixel;
    size_t  image_width;
    size_t  image_height;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bmpd_in_if.sv =====
`default_nettype none
interface bmpd_in_if;
  logic           valid;
  logic           ready;
  bmpd_pkg::byte_t data_byte;
  logic           file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink (input valid, input data_byte, input file_start, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bmpd_out_if.sv =====
`default_nettype none
interface bmpd_out_if;
  logic             valid;
  logic             ready;
  bmpd_pkg::kind_t  result_kind;
  bmpd_pkg::err_t   error_code;
  bmpd_pkg::byte_t  red;
  bmpd_pkg::byte_t  green;
  bmpd_pkg::byte_t  blue;
  bmpd_pkg::coord_t column;
  bmpd_pkg::coord_t row;
  logic             last_pixel;
  bmpd_pkg::size_t  image_width;
  bmpd_pkg::size_t  image_height;

  modport source (
    output valid, output result_kind, output error_code, output red, output green,
    output blue, output column, output row, output last_pixel, output image_width,
    output image_height, input ready
  );
  modport sink (
    input valid, input result_kind, input error_code, input red, input green,
    input blue, input column, input row, input last_pixel, input image_width,
    input image_height, output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/bmpd_in_stage.sv =====
`default_nettype none
module bmpd_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire bmpd_pkg::item_t in_data,
  input  wire logic            advance,
  output logic                 in_ready,
  output logic                 item_valid,
  output bmpd_pkg::item_t      item
);

  logic            valid_r;
  bmpd_pkg::item_t item_r;

  // free, or being drained this cycle
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bmpd_core.sv =====
`default_nettype none
module bmpd_core #(
  parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire bmpd_pkg::item_t item,
  output logic                 has_result,
  output bmpd_pkg::res_t       res
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef logic [WW-1:0] wd_t;
  typedef logic [HW-1:0] ht_t;

  bmpd_pkg::phase_t   phase_r, phase_nxt;
  bmpd_pkg::hdr_idx_t idx_r, idx_nxt;
  logic [31:0]        shift_r, shift_nxt;
  bmpd_pkg::err_t     fail_r, fail_nxt;
  wd_t                width_r, width_nxt;
  ht_t                height_r, height_nxt;
  wd_t                col_r, col_nxt;
  ht_t                srow_r, srow_nxt;
  logic [1:0]         bip_r, bip_nxt;
  logic [1:0]         pad_r, pad_nxt;
  bmpd_pkg::byte_t    blue_r, blue_nxt;
  bmpd_pkg::byte_t    green_r, green_nxt;

  // a file start restarts the header parse on this very byte
  bmpd_pkg::phase_t   phase_e;
  bmpd_pkg::hdr_idx_t idx_e;
  logic [31:0]        shift_e;
  bmpd_pkg::err_t     fail_e;
  logic [31:0]        sh;
  logic               busy;
  logic               chk_bad;
  bmpd_pkg::err_t     chk_code;
  bmpd_pkg::err_t     fail_n;
  logic               width_bad, height_bad;
  wd_t                col_inc;
  ht_t                srow_inc;
  logic               row_end, img_end;
  logic [1:0]         pad_fill;

  assign phase_e = item.file_start ? bmpd_pkg::PH_HEADER : phase_r;
  assign idx_e   = item.file_start ? '0 : idx_r;
  assign shift_e = item.file_start ? '0 : shift_r;
  assign fail_e  = item.file_start ? bmpd_pkg::NO_FAIL : fail_r;
  assign sh      = {item.data_byte, shift_e[31:8]};
  assign busy    = (phase_r == bmpd_pkg::PH_HEADER) || (phase_r == bmpd_pkg::PH_PIXELS);

  assign width_bad  = sh[31] || (sh > 32'(MAX_WIDTH));
  assign height_bad = sh[31] || (sh > 32'(MAX_HEIGHT));

  // field check at the byte that completes it
  always_comb begin
    chk_bad  = 1'b0;
    chk_code = bmpd_pkg::NO_FAIL;
    unique case (idx_e)
      bmpd_pkg::IDX_SIG: begin
        chk_bad  = sh[31:16] != bmpd_pkg::SIG_BM;
        chk_code = bmpd_pkg::ERR_SIGNATURE;
      end
      bmpd_pkg::IDX_OFFSET: begin
        chk_bad  = sh != bmpd_pkg::PIXEL_OFFSET;
        chk_code = bmpd_pkg::ERR_OFFSET;
      end
      bmpd_pkg::IDX_INFO: begin
        chk_bad  = sh != bmpd_pkg::INFO_SIZE;
        chk_code = bmpd_pkg::ERR_INFO_SIZE;
      end
      bmpd_pkg::IDX_WIDTH: begin
        chk_bad  = width_bad;
        chk_code = bmpd_pkg::ERR_SIZE;
      end
      bmpd_pkg::IDX_HEIGHT: begin
        chk_bad  = height_bad;
        chk_code = bmpd_pkg::ERR_SIZE;
      end
      bmpd_pkg::IDX_PLANES: begin
        chk_bad  = sh[31:16] != bmpd_pkg::PLANES;
        chk_code = bmpd_pkg::ERR_PLANES;
      end
      bmpd_pkg::IDX_DEPTH: begin
        chk_bad  = sh[31:16] != bmpd_pkg::BITS_PER_PIX;
        chk_code = bmpd_pkg::ERR_DEPTH;
      end
      bmpd_pkg::IDX_COMPRESS: begin
        chk_bad  = sh != '0;
        chk_code = bmpd_pkg::ERR_COMPRESSION;
      end
      bmpd_pkg::IDX_PALETTE: begin
        chk_bad  = sh != '0;
        chk_code = bmpd_pkg::ERR_PALETTE;
      end
      default: begin
        chk_bad  = 1'b0;
        chk_code = bmpd_pkg::NO_FAIL;
      end
    endcase
  end

  assign fail_n = (chk_bad && (chk_code < fail_e)) ? chk_code : fail_e;

  assign col_inc  = col_r + wd_t'(1);
  assign srow_inc = srow_r + ht_t'(1);
  assign row_end  = col_inc >= width_r;
  assign img_end  = srow_inc >= height_r;
  assign pad_fill = 2'(width_r);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    shift_nxt  = shift_r;
    fail_nxt   = fail_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    srow_nxt   = srow_r;
    bip_nxt    = bip_r;
    pad_nxt    = pad_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    if (step) begin
      if (phase_e == bmpd_pkg::PH_HEADER) begin
        phase_nxt = bmpd_pkg::PH_HEADER;
        shift_nxt = sh;
        idx_nxt   = idx_e + bmpd_pkg::hdr_idx_t'(1);
        fail_nxt  = fail_n;
        unique case (idx_e)
          bmpd_pkg::IDX_WIDTH: begin
            width_nxt = width_bad ? '0 : wd_t'(sh);
          end
          bmpd_pkg::IDX_HEIGHT: begin
            height_nxt = height_bad ? '0 : ht_t'(sh);
          end
          bmpd_pkg::IDX_OFFSET: begin
            if (fail_n != bmpd_pkg::NO_FAIL) begin
              phase_nxt = bmpd_pkg::PH_IDLE;
            end
          end
          bmpd_pkg::IDX_LAST: begin
            col_nxt  = '0;
            srow_nxt = '0;
            bip_nxt  = '0;
            pad_nxt  = '0;
            if (fail_n != bmpd_pkg::NO_FAIL || width_r == '0 || height_r == '0) begin
              phase_nxt = bmpd_pkg::PH_IDLE;
            end else begin
              phase_nxt = bmpd_pkg::PH_PIXELS;
            end
          end
          default: begin
          end
        endcase
      end else if (phase_e == bmpd_pkg::PH_PIXELS) begin
        if (pad_r != '0) begin
          pad_nxt = pad_r - 2'd1;
          if (pad_r == 2'd1) begin
            srow_nxt = srow_inc;
            if (img_end) begin
              phase_nxt = bmpd_pkg::PH_IDLE;
            end
          end
        end else begin
          unique case (bip_r)
            2'd0: begin
              blue_nxt = item.data_byte;
              bip_nxt  = 2'd1;
            end
            2'd1: begin
              green_nxt = item.data_byte;
              bip_nxt   = 2'd2;
            end
            default: begin
              bip_nxt = 2'd0;
              if (row_end) begin
                col_nxt = '0;
                pad_nxt = pad_fill;
                if (pad_fill == '0) begin
                  srow_nxt = srow_inc;
                  if (img_end) begin
                    phase_nxt = bmpd_pkg::PH_IDLE;
                  end
                end
              end else begin
                col_nxt = col_inc;
              end
            end
          endcase
        end
      end
    end
  end

  // result of this byte
  always_comb begin
    has_result = 1'b0;
    res        = '0;
    if (step) begin
      if (item.file_start && busy) begin
        has_result      = 1'b1;
        res.result_kind = bmpd_pkg::KIND_ERROR;
        res.error_code  = bmpd_pkg::ERR_TRUNCATED;
      end else if (phase_e == bmpd_pkg::PH_HEADER) begin
        if ((idx_e == bmpd_pkg::IDX_OFFSET || idx_e == bmpd_pkg::IDX_LAST) &&
            fail_n != bmpd_pkg::NO_FAIL) begin
          has_result      = 1'b1;
          res.result_kind = bmpd_pkg::KIND_ERROR;
          res.error_code  = fail_n;
        end else if (idx_e == bmpd_pkg::IDX_LAST) begin
          has_result       = 1'b1;
          res.result_kind  = bmpd_pkg::KIND_HEADER;
          res.image_width  = bmpd_pkg::size_t'(width_r);
          res.image_height = bmpd_pkg::size_t'(height_r);
        end
      end else if (phase_e == bmpd_pkg::PH_PIXELS && pad_r == '0 && bip_r == 2'd2) begin
        has_result      = 1'b1;
        res.result_kind = bmpd_pkg::KIND_PIXEL;
        res.red         = item.data_byte;
        res.green       = green_r;
        res.blue        = blue_r;
        res.column      = bmpd_pkg::coord_t'(col_r);
        res.row         = bmpd_pkg::coord_t'(height_r - ht_t'(1) - srow_r);
        res.last_pixel  = (col_inc == width_r) && (srow_inc == height_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bmpd_pkg::PH_IDLE;
      idx_r    <= '0;
      shift_r  <= '0;
      fail_r   <= bmpd_pkg::NO_FAIL;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      srow_r   <= '0;
      bip_r    <= '0;
      pad_r    <= '0;
      blue_r   <= '0;
      green_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      shift_r  <= shift_nxt;
      fail_r   <= fail_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      srow_r   <= srow_nxt;
      bip_r    <= bip_nxt;
      pad_r    <= pad_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bmpd_out_stage.sv =====
`default_nettype none
module bmpd_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire bmpd_pkg::res_t res_in,
  input  wire logic           out_ready,
  output logic                can_take,
  output logic                out_valid,
  output bmpd_pkg::res_t      res_out
);

  logic           valid_r;
  bmpd_pkg::res_t res_r;

  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bmp_24bit_stream_decoder.sv =====
// streaming decoder for uncompressed 24-bit bitmap files
// in_item: one file byte per item, file_start marks the first byte of a file
// out_item: at most one result per byte: header accepted with width and
//   height, an error code, or a pixel with column, top-down row and last flag
// each accepted byte is held in an input register, then decoded combinationally
//   into the result register once that register can take a result
// throughput is one byte per clock as long as out_item.ready stays high
// bytes that give no result (header bytes, blue and green, row padding, idle
//   bytes) still pass through the decode stage but load nothing
// when the receiver stalls with a result pending, the decode stage holds its
//   byte and in_item.ready drops in the same cycle (ready path is combinational
//   from out_item.ready)
// after reset the parser is idle and ignores bytes until a file start
// an error sends the parser idle; a file start mid-file reports truncation
//   and still opens the new file
module bmp_24bit_stream_decoder #(
  parameter int MAX_WIDTH  = bmpd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmpd_pkg::MAX_HEIGHT_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  bmpd_in_if.sink    in_item,
  bmpd_out_if.source out_item
);

  bmpd_pkg::item_t in_data;
  bmpd_pkg::item_t item;
  logic            item_valid;
  logic            advance;
  logic            can_take;
  logic            has_result;
  bmpd_pkg::res_t  res;
  bmpd_pkg::res_t  res_q;

  assign in_data.data_byte  = in_item.data_byte;
  assign in_data.file_start = in_item.file_start;

  // decode the held byte whenever the result register has room, whether or not the byte gives a result
  assign advance = item_valid && can_take;

  bmpd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_item.valid),
    .in_data    (in_data),
    .advance    (advance),
    .in_ready   (in_item.ready),
    .item_valid (item_valid),
    .item       (item)
  );

  bmpd_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (item),
    .has_result (has_result),
    .res        (res)
  );

  bmpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && has_result),
    .res_in    (res),
    .out_ready (out_item.ready),
    .can_take  (can_take),
    .out_valid (out_item.valid),
    .res_out   (res_q)
  );

  assign out_item.result_kind  = res_q.result_kind;
  assign out_item.error_code   = res_q.error_code;
  assign out_item.red          = res_q.red;
  assign out_item.green        = res_q.green;
  assign out_item.blue         = res_q.blue;
  assign out_item.column       = res_q.column;
  assign out_item.row          = res_q.row;
  assign out_item.last_pixel   = res_q.last_pixel;
  assign out_item.image_width  = res_q.image_width;
  assign out_item.image_height = res_q.image_height;

endmodule
`default_nettype wire

// ===== hw/rtl/bmpd_checker.sv =====
`default_nettype none
module bmpd_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire bmpd_pkg::kind_t result_kind,
  input wire bmpd_pkg::err_t  error_code,
  input wire logic            last_pixel
);

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(error_code))
    else $error("stalled result changed");

  // input backpressure only comes from a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // error code is zero on anything but an error
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind != bmpd_pkg::KIND_ERROR |-> error_code == '0)
    else $error("error code on non-error result");

  // last flag only on pixels
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_pixel |-> result_kind == bmpd_pkg::KIND_PIXEL)
    else $error("last flag on non-pixel result");

endmodule

bind bmp_24bit_stream_decoder bmpd_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_item.ready),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .result_kind (out_item.result_kind),
  .error_code  (out_item.error_code),
  .last_pixel  (out_item.last_pixel)
);
`default_nettype wire

// ===== verif/bmp_24bit_stream_decoder_test.sv =====
`timescale 1ns / 100ps

module bmp_24bit_stream_decoder_test;

  localparam int unsigned MAX_W = bmpd_pkg::MAX_WIDTH_DEF;
  localparam int unsigned MAX_H = bmpd_pkg::MAX_HEIGHT_DEF;
  localparam int HDR_BYTES = 54;
  localparam int RANDOM_BUDGET = 50;    // bytes of random files per flow phase
  localparam int HOLD_LEN = 300;        // receiver hold-off in the pressure phase
  localparam int SETTLE_CYCLES = 8;     // settling wait before the summary is printed
  localparam int CYCLE_LIMIT = 600000;
  localparam int SHOW_MAX = 10;

  // how the two sides of the block pace themselves
  typedef enum logic [2:0] {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH,
    FLOW_HOLD_OFF
  } flow_t;

  // header fields that the stimulus can set or spoil
  typedef struct {
    logic [15:0] sig;
    logic [31:0] offs;
    logic [31:0] info;
    logic [31:0] wid;
    logic [31:0] hgt;
    logic [15:0] planes;
    logic [15:0] bpp;
    logic [31:0] comp;
    logic [31:0] pal;
  } hdr_fields_t;

  logic clk = 1'b0;
  logic rst_n;

  bmpd_in_if  in_if ();
  bmpd_out_if out_if ();

  bmp_24bit_stream_decoder u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_if),
    .out_item(out_if)
  );

  always #10 clk = ~clk;

  // file bytes waiting to be sent, and decoder results still to arrive
  bmpd_pkg::item_t byte_queue[$];
  bmpd_pkg::res_t  awaited[$];

  flow_t flow_mode = FLOW_FREE;
  bit    byte_taken = 1'b0;
  int    bytes_queued = 0;
  int    bytes_accepted = 0;
  int    files_started = 0;
  int    pixels_seen = 0;
  int    headers_seen = 0;
  int    errors_seen = 0;
  int    mismatches = 0;
  int    cycles = 0;
  int    held_cycles = 0;

  // ---------------------------------------------------------------------------
  // predictor: mirror of the parser state
  // ---------------------------------------------------------------------------
  bmpd_pkg::phase_t   prs_phase = bmpd_pkg::PH_IDLE;
  bmpd_pkg::hdr_idx_t prs_idx = '0;
  logic [31:0]        prs_shift = '0;
  bmpd_pkg::err_t     prs_fail = bmpd_pkg::NO_FAIL;
  bmpd_pkg::size_t    img_w = '0;
  bmpd_pkg::size_t    img_h = '0;
  bmpd_pkg::size_t    col_cnt = '0;    // one bit wider than a column so it can reach the width
  bmpd_pkg::size_t    row_cnt = '0;    // same for stored rows against the height
  logic [1:0]         pix_byte = '0;
  logic [1:0]         pad_left = '0;
  bmpd_pkg::byte_t    hold_b = '0;
  bmpd_pkg::byte_t    hold_g = '0;

  // lowest failing code wins
  function automatic void note_fail(bmpd_pkg::err_t code);
    if (code < prs_fail) prs_fail = code;
  endfunction

  function automatic void end_row();
    row_cnt = row_cnt + 13'd1;
    if (row_cnt >= img_h) prs_phase = bmpd_pkg::PH_IDLE;
  endfunction

  // one header byte: shift it in little-endian and check the field it completes
  function automatic bit header_step(bmpd_pkg::byte_t b, output bmpd_pkg::res_t r);
    logic [31:0] sh;
    bmpd_pkg::hdr_idx_t at;
    bit done;
    sh = {b, prs_shift[31:8]};
    at = prs_idx;
    prs_shift = sh;
    prs_idx = at + 6'd1;
    r = '0;
    done = 1'b0;
    case (at)
      bmpd_pkg::IDX_SIG: if (sh[31:16] != bmpd_pkg::SIG_BM) note_fail(bmpd_pkg::ERR_SIGNATURE);
      bmpd_pkg::IDX_OFFSET: begin
        if (sh != bmpd_pkg::PIXEL_OFFSET) note_fail(bmpd_pkg::ERR_OFFSET);
        // file header failures come out on the 14th byte
        if (prs_fail != bmpd_pkg::NO_FAIL) begin
          r.result_kind = bmpd_pkg::KIND_ERROR;
          r.error_code = prs_fail;
          prs_phase = bmpd_pkg::PH_IDLE;
          done = 1'b1;
        end
      end
      bmpd_pkg::IDX_INFO: if (sh != bmpd_pkg::INFO_SIZE) note_fail(bmpd_pkg::ERR_INFO_SIZE);
      bmpd_pkg::IDX_WIDTH: begin
        // negative or oversize width
        if (sh[31] || sh > MAX_W) begin
          note_fail(bmpd_pkg::ERR_SIZE);
          img_w = '0;
        end else begin
          img_w = bmpd_pkg::size_t'(sh);
        end
      end
      bmpd_pkg::IDX_HEIGHT: begin
        if (sh[31] || sh > MAX_H) begin
          note_fail(bmpd_pkg::ERR_SIZE);
          img_h = '0;
        end else begin
          img_h = bmpd_pkg::size_t'(sh);
        end
      end
      bmpd_pkg::IDX_PLANES: if (sh[31:16] != bmpd_pkg::PLANES) note_fail(bmpd_pkg::ERR_PLANES);
      bmpd_pkg::IDX_DEPTH:
        if (sh[31:16] != bmpd_pkg::BITS_PER_PIX) note_fail(bmpd_pkg::ERR_DEPTH);
      bmpd_pkg::IDX_COMPRESS: if (sh != '0) note_fail(bmpd_pkg::ERR_COMPRESSION);
      bmpd_pkg::IDX_PALETTE: if (sh != '0) note_fail(bmpd_pkg::ERR_PALETTE);
      bmpd_pkg::IDX_LAST: begin
        done = 1'b1;
        if (prs_fail != bmpd_pkg::NO_FAIL) begin
          r.result_kind = bmpd_pkg::KIND_ERROR;
          r.error_code = prs_fail;
          prs_phase = bmpd_pkg::PH_IDLE;
        end else begin
          r.result_kind = bmpd_pkg::KIND_HEADER;
          r.image_width = img_w;
          r.image_height = img_h;
          col_cnt = '0;
          row_cnt = '0;
          pix_byte = '0;
          pad_left = '0;
          // an empty image ends right at its header
          prs_phase = (img_w == '0 || img_h == '0) ? bmpd_pkg::PH_IDLE : bmpd_pkg::PH_PIXELS;
        end
      end
      default: ;
    endcase
    return done;
  endfunction

  // one accepted item: update the mirror and queue the result it causes
  function automatic void decode_byte(bmpd_pkg::item_t it);
    bmpd_pkg::res_t r;
    bit got;
    bit busy;
    r = '0;
    got = 1'b0;
    if (it.file_start) begin
      busy = (prs_phase == bmpd_pkg::PH_HEADER || prs_phase == bmpd_pkg::PH_PIXELS);
      prs_phase = bmpd_pkg::PH_HEADER;
      prs_idx = '0;
      prs_shift = '0;
      prs_fail = bmpd_pkg::NO_FAIL;
      got = header_step(it.data_byte, r);
      // restart mid-file: truncation reported, the byte still opens the new file
      if (busy) begin
        r = '0;
        r.result_kind = bmpd_pkg::KIND_ERROR;
        r.error_code = bmpd_pkg::ERR_TRUNCATED;
        got = 1'b1;
      end
    end else if (prs_phase == bmpd_pkg::PH_HEADER) begin
      got = header_step(it.data_byte, r);
    end else if (prs_phase == bmpd_pkg::PH_PIXELS) begin
      if (pad_left != '0) begin
        // row padding, the last row's too
        pad_left = pad_left - 2'd1;
        if (pad_left == '0) end_row();
      end else if (pix_byte == 2'd0) begin
        hold_b = it.data_byte;
        pix_byte = 2'd1;
      end else if (pix_byte == 2'd1) begin
        hold_g = it.data_byte;
        pix_byte = 2'd2;
      end else begin
        r.result_kind = bmpd_pkg::KIND_PIXEL;
        r.red = it.data_byte;
        r.green = hold_g;
        r.blue = hold_b;
        r.column = bmpd_pkg::coord_t'(col_cnt);
        // stored bottom-up, reported top-down
        r.row = bmpd_pkg::coord_t'(img_h - 13'd1 - row_cnt);
        r.last_pixel = (col_cnt + 13'd1 == img_w) && (row_cnt + 13'd1 == img_h);
        got = 1'b1;
        pix_byte = 2'd0;
        col_cnt = col_cnt + 13'd1;
        if (col_cnt >= img_w) begin
          col_cnt = '0;
          pad_left = img_w[1:0];
          if (pad_left == '0) end_row();
        end
      end
    end
    // idle bytes without a file start are dropped
    if (got) awaited.insert(awaited.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  function automatic hdr_fields_t plain_header(int unsigned w, int unsigned h);
    hdr_fields_t f;
    f.sig = bmpd_pkg::SIG_BM;
    f.offs = bmpd_pkg::PIXEL_OFFSET;
    f.info = bmpd_pkg::INFO_SIZE;
    f.wid = w;
    f.hgt = h;
    f.planes = bmpd_pkg::PLANES;
    f.bpp = bmpd_pkg::BITS_PER_PIX;
    f.comp = '0;
    f.pal = '0;
    return f;
  endfunction

  // queue one file; keep >= 0 cuts it short, extreme fills pixels with 00/ff
  function automatic int queue_file(hdr_fields_t f, int keep, bit extreme);
    bmpd_pkg::byte_t hdr [HDR_BYTES];
    int unsigned body;
    int total;
    int k;
    bmpd_pkg::byte_t b;
    bmpd_pkg::item_t it;
    for (k = 0; k < HDR_BYTES; k++) hdr[k] = bmpd_pkg::byte_t'($urandom);
    for (k = 0; k < 2; k++) begin
      hdr[k] = f.sig[8*k +: 8];
      hdr[26+k] = f.planes[8*k +: 8];
      hdr[28+k] = f.bpp[8*k +: 8];
    end
    for (k = 0; k < 4; k++) begin
      hdr[10+k] = f.offs[8*k +: 8];
      hdr[14+k] = f.info[8*k +: 8];
      hdr[18+k] = f.wid[8*k +: 8];
      hdr[22+k] = f.hgt[8*k +: 8];
      hdr[30+k] = f.comp[8*k +: 8];
      hdr[46+k] = f.pal[8*k +: 8];
    end
    body = 0;
    if (f.sig == bmpd_pkg::SIG_BM && f.offs == bmpd_pkg::PIXEL_OFFSET &&
        f.info == bmpd_pkg::INFO_SIZE && f.planes == bmpd_pkg::PLANES &&
        f.bpp == bmpd_pkg::BITS_PER_PIX && f.comp == '0 && f.pal == '0 &&
        f.wid <= MAX_W && f.hgt <= MAX_H)
      body = f.hgt * (3 * f.wid + f.wid[1:0]);
    total = HDR_BYTES + body;
    if (keep >= 0 && keep < total) total = keep;
    for (k = 0; k < total; k++) begin
      if (k < HDR_BYTES) b = hdr[k];
      else if (extreme) b = k[0] ? 8'hFF : 8'h00;
      else b = bmpd_pkg::byte_t'($urandom);
      it.data_byte = b;
      it.file_start = (k == 0);
      byte_queue.insert(byte_queue.size(), it);
    end
    bytes_queued += total;
    return total;
  endfunction

  // stray bytes, now and then with a file start, so the next file's start reports truncation
  function automatic int queue_noise(int n);
    int k;
    bmpd_pkg::item_t it;
    for (k = 0; k < n; k++) begin
      it.data_byte = bmpd_pkg::byte_t'($urandom);
      it.file_start = ($urandom_range(15) == 0);
      byte_queue.insert(byte_queue.size(), it);
    end
    bytes_queued += n;
    return n;
  endfunction

  // mostly well-formed small files with random content, some spoiled or cut
  function automatic void queue_random_files(int budget);
    hdr_fields_t f;
    int spent;
    int pick;
    int keep;
    spent = 0;
    while (spent < budget) begin
      pick = $urandom_range(99);
      f = plain_header($urandom_range(1, 4), $urandom_range(1, 2));
      keep = -1;
      if (pick < 6) begin
        if (pick[0]) f.wid = '0;
        else f.hgt = '0;
      end else if (pick < 22) begin
        case ($urandom_range(8))
          0: f.sig = 16'($urandom);
          1: f.offs = $urandom_range(1) ? $urandom : bmpd_pkg::PIXEL_OFFSET + 1;
          2: f.info = $urandom_range(1) ? $urandom : bmpd_pkg::INFO_SIZE + 1;
          3: f.wid = $urandom_range(1) ? (32'h8000_0000 | $urandom) :
                                         MAX_W + 1 + $urandom_range(99);
          4: f.hgt = $urandom_range(1) ? (32'h8000_0000 | $urandom) :
                                         MAX_H + 1 + $urandom_range(99);
          5: f.planes = 16'($urandom_range(2, 65535));
          6: f.bpp = 16'($urandom);
          7: f.comp = $urandom_range(1, 3);
          default: f.pal = $urandom_range(1, 256);
        endcase
      end else if (pick < 32) begin
        keep = $urandom_range(1, 100);
      end
      if ($urandom_range(7) == 0) spent += queue_noise($urandom_range(1, 4));
      spent += queue_file(f, keep, 1'b0);
    end
  endfunction

  function automatic bit send_gap();
    case (flow_mode)
      FLOW_SEND_GAPS: return $urandom_range(99) < 62;
      FLOW_BOTH:      return $urandom_range(99) < 31;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (flow_mode)
      FLOW_RECV_STALLS: return $urandom_range(99) < 62;
      FLOW_BOTH:        return $urandom_range(99) < 31;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic string res_text(bmpd_pkg::res_t r);
    return $sformatf("kind=%0d err=%0d rgb=%02h/%02h/%02h col=%0d row=%0d last=%0b w=%0d h=%0d",
                     r.result_kind, r.error_code, r.red, r.green, r.blue, r.column, r.row,
                     r.last_pixel, r.image_width, r.image_height);
  endfunction

  function automatic void flag_result(string why, string want_txt, bmpd_pkg::res_t got);
    mismatches++;
    if (mismatches <= SHOW_MAX)
      $display("%0t: %s\n  expected %s\n  actual   %s", $realtime, why, want_txt,
               res_text(got));
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one file byte per item, changed at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_bytes
    bmpd_pkg::item_t nxt;
    if (rst_n && (!in_if.valid || byte_taken)) begin
      if (byte_queue.size() != 0 && !send_gap()) begin
        nxt = byte_queue.pop_front();
        in_if.valid <= 1'b1;
        in_if.data_byte <= nxt.data_byte;
        in_if.file_start <= nxt.file_start;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or one long hold-off so the block backs up
  always @(negedge clk) begin
    if (flow_mode == FLOW_HOLD_OFF && held_cycles < HOLD_LEN) begin
      held_cycles <= held_cycles + 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !recv_stall();
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check results first, then predict from the byte taken at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    bmpd_pkg::res_t got;
    bmpd_pkg::res_t want;
    byte_taken = 1'b0;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = '{result_kind: out_if.result_kind, error_code: out_if.error_code,
                red: out_if.red, green: out_if.green, blue: out_if.blue,
                column: out_if.column, row: out_if.row, last_pixel: out_if.last_pixel,
                image_width: out_if.image_width, image_height: out_if.image_height};
        case (got.result_kind)
          bmpd_pkg::KIND_PIXEL:  pixels_seen++;
          bmpd_pkg::KIND_HEADER: headers_seen++;
          default:               errors_seen++;
        endcase
        if (awaited.size() == 0) begin
          flag_result("result with nothing expected", "nothing", got);
        end else begin
          want = awaited.pop_front();
          if (got.result_kind !== want.result_kind || got.error_code !== want.error_code ||
              got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.column !== want.column || got.row !== want.row ||
              got.last_pixel !== want.last_pixel || got.image_width !== want.image_width ||
              got.image_height !== want.image_height)
            flag_result("result mismatch", res_text(want), got);
        end
      end
      byte_taken = in_if.valid && in_if.ready;
      if (byte_taken) begin
        bytes_accepted++;
        if (in_if.file_start) files_started++;
        decode_byte('{data_byte: in_if.data_byte, file_start: in_if.file_start});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, awaited.size());
      $display("tb: failure");
      $finish;
    end
  end

  // every queued byte taken and every predicted result seen
  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || awaited.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    hdr_fields_t f;
    flow_t mode;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.file_start = 1'b0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed files, free flow
    void'(queue_noise(3));                                 // bytes before any file start
    void'(queue_file(plain_header(3, 2), -1, 1'b1));       // 00/ff pixels, three pad bytes per row
    f = plain_header(2, 2); f.sig = 16'h4D43;
    void'(queue_file(f, 14, 1'b0));                        // error on the 14th byte, rest dropped
    void'(queue_noise(2));                                 // ignored while idle after the error
    f = plain_header(2, 2); f.offs = 32'd55;
    void'(queue_file(f, 14, 1'b0));
    f = plain_header(2, 2); f.info = 32'd124; f.wid = 32'hFFFF_FFFF;
    void'(queue_file(f, -1, 1'b0));                        // info size beats size
    void'(queue_file(plain_header(3, 2), 20, 1'b0));       // cut in the header, next start truncates

    // random files under free flow, sender gaps, receiver stalls and both
    for (int p = 0; p < 4; p++) begin
      mode = flow_t'(p);
      flow_mode = mode;
      queue_random_files(RANDOM_BUDGET);
      wait_drained();
    end

    // receiver holds off while the sender keeps offering bytes
    flow_mode = FLOW_HOLD_OFF;
    void'(queue_file(plain_header(1, 2), -1, 1'b0));
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("summary: %0d bytes in %0d files, %0d pixels, %0d headers accepted, %0d errors",
             bytes_accepted, files_started, pixels_seen, headers_seen, errors_seen);
    $display("summary: free flow, sender gaps, receiver stalls, both, long hold-off; %0d mismatches",
             mismatches);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
